// ===== hw/rtl/windowed_record_stats_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for windowed_record_stats
// Clocked checks, reset-qualified, reporting via $error.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RECORD_STATS_ASSERT_SVH
`define WINDOWED_RECORD_STATS_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WRS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define WRS_ASSERT(label, prop, msg)
`define WRS_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== hw/rtl/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types, codes and date helpers for the windowed record statistics.
// ----------------------------------------------------------------------------
package wrs_pkg;

  localparam int unsigned DAY_W = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LATEST,
    ST_ACCUM,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic [6:0]         year;
    logic [1:0]         kind;
    logic signed [15:0] value;
  } rec_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic init;
    logic find_latest;
    logic accumulate;
  } stats_ctl_t;

  // days in the months before the given one; months past 12 count the whole year
  function automatic logic [8:0] cum_days(input logic [3:0] month, input logic leap);
    logic [8:0] d;
    unique case (month)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    if (leap && month >= 4'd3) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  // day number with 1 Jan 2000 as day 1; every fourth year is leap except 2100
  function automatic logic [DAY_W-1:0] day_number(input rec_t r);
    logic [DAY_W-1:0] yr_days;
    logic [7:0]       leaps;
    logic             leap;
    yr_days = DAY_W'(r.year) * DAY_W'(365);
    leaps   = (8'(r.year) + 8'd3) >> 2;
    if (r.year > 7'd100) begin
      leaps = leaps - 8'd1;
    end
    leap    = (r.year[1:0] == 2'b00) && (r.year != 7'd100);
    return yr_days + DAY_W'(leaps) + DAY_W'(cum_days(r.month, leap)) + DAY_W'(r.day);
  endfunction

endpackage

// ===== hw/rtl/windowed_record_stats.sv =====
// ----------------------------------------------------------------------------
// windowed_record_stats
// Store of dated measurement records with windowed count/min/max/sum/mean.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one transaction: load writes a
// slot, clear empties the store, query asks for statistics of one type over a
// day window ending at the latest stored date. Output channel
// (out_valid_o/out_ready_i) gives one transaction per query only.
// Load and clear finish as they are accepted. A query circulates the record ring
// twice (latest date, then accumulation), then runs the mean divider for one bit
// per cycle over a numerator of 16 + clog2(RECORDS+1) + 8 bits, with a start state
// before it and a finish state after it.
// in_ready_o is high only between queries; loads and clears go back to back.
// A finished result waits in the output register; a later query may run
// while it waits and holds its own result until the register is free.
// Reset empties every slot (all fields zero) at once and clears
// the output valid.
// ----------------------------------------------------------------------------
module windowed_record_stats #(
  parameter int unsigned RECORDS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [3:0]         slot_i,
  input  logic [4:0]         rec_day_i,
  input  logic [3:0]         rec_month_i,
  input  logic [6:0]         rec_year_i,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] sample_i,
  input  logic [7:0]         window_days_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         match_count_o,
  output logic signed [15:0] min_value_o,
  output logic signed [15:0] max_value_o,
  output logic signed [19:0] value_sum_o,
  output logic signed [23:0] mean_q8_o
);

  localparam int unsigned IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int unsigned CNT_W = $clog2(RECORDS + 1);
  localparam int unsigned SUM_W = 16 + CNT_W;
  localparam int unsigned NUM_W = SUM_W + 8;

  wrs_pkg::state_e     state_q, state_d;
  logic [IDX_W-1:0]    idx_q;
  logic                idx_last;
  logic                in_acc;
  wrs_pkg::func_e      func;
  wrs_pkg::cell_ctl_t  cell_ctl;
  wrs_pkg::stats_ctl_t stats_ctl;
  wrs_pkg::rec_t       load_rec;
  wrs_pkg::rec_t       ring [RECORDS];
  logic [1:0]          q_kind_q;
  logic [7:0]          q_window_q;
  logic [CNT_W-1:0]    st_count;
  logic signed [15:0]  st_min, st_max;
  logic signed [SUM_W-1:0] st_sum;
  logic [SUM_W-1:0]    sum_mag;
  logic                div_start, div_done;
  logic [NUM_W-1:0]    quo;
  logic                out_load;
  logic                out_valid_q;
  logic signed [31:0]  sum_wide;
  logic signed [19:0]  sum_sat;
  logic [23:0]         mean_mag;
  logic signed [23:0]  mean;

  assign func     = wrs_pkg::func_e'(func_i);
  assign in_ready_o = (state_q == wrs_pkg::ST_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign idx_last = (idx_q == IDX_W'(RECORDS - 1));

  assign load_rec.day   = rec_day_i;
  assign load_rec.month = rec_month_i;
  assign load_rec.year  = rec_year_i;
  assign load_rec.kind  = kind_i;
  assign load_rec.value = sample_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wrs_pkg::ST_IDLE:   if (in_acc && func == wrs_pkg::FUNC_QUERY) state_d = wrs_pkg::ST_LATEST;
      wrs_pkg::ST_LATEST: if (idx_last) state_d = wrs_pkg::ST_ACCUM;
      wrs_pkg::ST_ACCUM:  if (idx_last) state_d = wrs_pkg::ST_START;
      wrs_pkg::ST_START:  state_d = wrs_pkg::ST_DIVIDE;
      wrs_pkg::ST_DIVIDE: if (div_done) state_d = wrs_pkg::ST_FINISH;
      wrs_pkg::ST_FINISH: if (!out_valid_q || out_ready_i) state_d = wrs_pkg::ST_IDLE;
      default:            state_d = wrs_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cell_ctl.shift        = (state_q == wrs_pkg::ST_LATEST) || (state_q == wrs_pkg::ST_ACCUM);
    cell_ctl.clear        = in_acc && (func == wrs_pkg::FUNC_CLEAR);
    stats_ctl.init        = in_acc && (func == wrs_pkg::FUNC_QUERY);
    stats_ctl.find_latest = (state_q == wrs_pkg::ST_LATEST);
    stats_ctl.accumulate  = (state_q == wrs_pkg::ST_ACCUM);
    div_start             = (state_q == wrs_pkg::ST_START);
    out_load              = (state_q == wrs_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrs_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cell_ctl.shift) begin
        idx_q <= idx_last ? '0 : idx_q + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stats_ctl.init) begin
      q_kind_q   <= kind_i;
      q_window_q <= window_days_i;
    end
  end

  for (genvar i = 0; i < RECORDS; i++) begin : g_cell
    wrs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .load_i      (in_acc && (func == wrs_pkg::FUNC_LOAD) && (32'(slot_i) == i)),
      .load_rec_i  (load_rec),
      .shift_rec_i (ring[(i + RECORDS - 1) % RECORDS]),
      .rec_o       (ring[i])
    );
  end

  wrs_stats #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (stats_ctl),
    .rec_i    (ring[RECORDS-1]),
    .kind_i   (q_kind_q),
    .window_i (q_window_q),
    .count_o  (st_count),
    .min_o    (st_min),
    .max_o    (st_max),
    .sum_o    (st_sum)
  );

  assign sum_mag = st_sum[SUM_W-1] ? SUM_W'(-st_sum) : SUM_W'(st_sum);

  wrs_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({sum_mag, 8'h00}),
    .den_i   (st_count),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign sum_wide = 32'(st_sum);
  assign sum_sat  = (sum_wide > 32'sd524287)  ? 20'sh7FFFF :
                    (sum_wide < -32'sd524288) ? 20'sh80000 : sum_wide[19:0];
  assign mean_mag = quo[23:0];
  assign mean     = (st_count == '0) ? '0 :
                    st_sum[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      match_count_o <= (32'(st_count) > 32'd31) ? 5'd31 : 5'(st_count);
      min_value_o   <= st_min;
      max_value_o   <= st_max;
      value_sum_o   <= sum_sat;
      mean_q8_o     <= mean;
    end
  end

  assign out_valid_o = out_valid_q;

  `include "windowed_record_stats_assert.svh"

  `WRS_ASSERT_NEXT(a_finish_shows, out_load, out_valid_o, "finished result not presented")
  `WRS_ASSERT_NEXT(a_query_starts, (stats_ctl.init), (state_q == wrs_pkg::ST_LATEST), "query did not start")
  `WRS_ASSERT(a_count_range, (32'(st_count) <= RECORDS), "match count beyond store size")
  `WRS_ASSERT(a_busy_no_accept, ((state_q != wrs_pkg::ST_IDLE) |-> !in_ready_o), "input taken mid query")

endmodule

// ===== hw/rtl/wrs_cell.sv =====
// ----------------------------------------------------------------------------
// wrs_cell
// One record slot of the circulating store.
// ----------------------------------------------------------------------------
module wrs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wrs_pkg::cell_ctl_t ctl_i,
  input  logic              load_i,
  input  wrs_pkg::rec_t     load_rec_i,
  input  wrs_pkg::rec_t     shift_rec_i,
  output wrs_pkg::rec_t     rec_o
);

  wrs_pkg::rec_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      priority if (ctl_i.clear) begin
        rec_q <= '0;
      end else if (load_i) begin
        rec_q <= load_rec_i;
      end else if (ctl_i.shift) begin
        rec_q <= shift_rec_i;
      end
    end
  end

  assign rec_o = rec_q;

endmodule

// ===== hw/rtl/wrs_stats.sv =====
// ----------------------------------------------------------------------------
// wrs_stats
// Latest-date search and windowed min/max/sum/count over the record stream.
// ----------------------------------------------------------------------------
module wrs_stats #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned SUM_W = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wrs_pkg::stats_ctl_t      ctl_i,
  input  wrs_pkg::rec_t            rec_i,
  input  logic [1:0]               kind_i,
  input  logic [7:0]               window_i,
  output logic [CNT_W-1:0]         count_o,
  output logic signed [15:0]       min_o,
  output logic signed [15:0]       max_o,
  output logic signed [SUM_W-1:0]  sum_o
);

  logic [wrs_pkg::DAY_W-1:0]   dn;
  logic [wrs_pkg::DAY_W-1:0]   latest_q, latest_d;
  logic signed [wrs_pkg::DAY_W+1:0] low, dn_s;
  logic                        hit;
  logic [CNT_W-1:0]            count_q, count_d;
  logic signed [15:0]          min_q, min_d, max_q, max_d;
  logic signed [SUM_W-1:0]     sum_q, sum_d;

  assign dn   = wrs_pkg::day_number(rec_i);
  assign dn_s = $signed({2'b00, dn});
  assign low  = $signed({2'b00, latest_q}) - $signed({{(wrs_pkg::DAY_W-6){1'b0}}, window_i});
  assign hit  = (rec_i.kind == kind_i) && (dn_s >= low) && (dn <= latest_q);

  always_comb begin
    latest_d = latest_q;
    count_d  = count_q;
    min_d    = min_q;
    max_d    = max_q;
    sum_d    = sum_q;
    priority if (ctl_i.init) begin
      latest_d = '0;
      count_d  = '0;
      min_d    = '0;
      max_d    = '0;
      sum_d    = '0;
    end else if (ctl_i.find_latest) begin
      if (dn > latest_q) begin
        latest_d = dn;
      end
    end else if (ctl_i.accumulate && hit) begin
      if (count_q == '0) begin
        min_d = rec_i.value;
        max_d = rec_i.value;
      end else begin
        if (rec_i.value < min_q) min_d = rec_i.value;
        if (rec_i.value > max_q) max_d = rec_i.value;
      end
      sum_d   = sum_q + SUM_W'(rec_i.value);
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= '0;
      count_q  <= '0;
      min_q    <= '0;
      max_q    <= '0;
      sum_q    <= '0;
    end else begin
      latest_q <= latest_d;
      count_q  <= count_d;
      min_q    <= min_d;
      max_q    <= max_d;
      sum_q    <= sum_d;
    end
  end

  assign count_o = count_q;
  assign min_o   = min_q;
  assign max_o   = max_q;
  assign sum_o   = sum_q;

endmodule

// ===== hw/rtl/wrs_div.sv =====
// ----------------------------------------------------------------------------
// wrs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrs_div #(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              run_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W:0]    rem_q, rem_shift, rem_sub;
  logic              take;

  assign rem_shift = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign take      = (rem_shift >= {1'b0, den_i});
  assign rem_sub   = rem_shift - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      step_q <= '0;
    end else if (run_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(NUM_W - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[NUM_W-2:0], take};
      rem_q <= take ? rem_sub : rem_shift;
    end
  end

  assign done_o = run_q && (step_q == STEP_W'(NUM_W - 1));
  assign quo_o  = quo_q;

endmodule
